// ===== sv/mse_pkg.sv =====
package mse_pkg;
   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_SLTI  = 6'h0A;
   localparam logic [5:0] OP_ANDI  = 6'h0C;
   localparam logic [5:0] OP_ORI   = 6'h0D;
   localparam logic [5:0] OP_LUI   = 6'h0F;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SW    = 6'h2B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_SLT   = 6'h2A;
   localparam logic [31:0] DMEM_BASE = 32'h1000_0000;

   localparam logic [3:0] K_NOP  = 4'd0;
   localparam logic [3:0] K_ADD  = 4'd1;
   localparam logic [3:0] K_SUB  = 4'd2;
   localparam logic [3:0] K_AND  = 4'd3;
   localparam logic [3:0] K_OR   = 4'd4;
   localparam logic [3:0] K_SLT  = 4'd5;
   localparam logic [3:0] K_LUI  = 4'd6;
   localparam logic [3:0] K_LW   = 4'd7;
   localparam logic [3:0] K_SW   = 4'd8;
   localparam logic [3:0] K_BEQ  = 4'd9;
   localparam logic [3:0] K_BNE  = 4'd10;
   localparam logic [3:0] K_J    = 4'd11;

   typedef struct packed {
      logic [3:0]  kind;
      logic        use_imm;
      logic [31:0] imm;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  dest;
      logic [25:0] target;
      logic        unknown;
   } uop_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  dest_reg;
      logic [31:0] dest_value;
      logic        mem_stored;
      logic [31:0] store_addr;
      logic [31:0] store_value;
      logic        addr_fault;
      logic        unknown_op;
   } rsp_type;
endpackage

// ===== sv/mse_if.sv =====
interface mse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;
   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface mse_rsp_if
   import mse_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/mse_ram.sv =====
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/mse_decode.sv =====
module mse_decode
   import mse_pkg::*;
(
   input  logic [31:0] instruction,
   output uop_type     uop
);
   logic [5:0]  op;
   logic [5:0]  fn;
   logic [31:0] sx;
   always_comb begin
      op = instruction[31:26];
      fn = instruction[5:0];
      sx = {{16{instruction[15]}}, instruction[15:0]};
      uop = '0;
      uop.rs = instruction[25:21];
      uop.rt = instruction[20:16];
      uop.target = instruction[25:0];
      uop.imm = sx;
      uop.dest = instruction[20:16];
      uop.kind = K_NOP;
      if (instruction == 32'd0) begin
         uop.kind = K_NOP;
      end else if (op == OP_RTYPE) begin
         uop.dest = instruction[15:11];
         unique case (fn)
            FN_ADD:  uop.kind = K_ADD;
            FN_SUB:  uop.kind = K_SUB;
            FN_AND:  uop.kind = K_AND;
            FN_OR:   uop.kind = K_OR;
            FN_SLT:  uop.kind = K_SLT;
            default: uop.unknown = 1'b1;
         endcase
      end else begin
         uop.use_imm = 1'b1;
         unique case (op)
            OP_ADDI: uop.kind = K_ADD;
            OP_SLTI: uop.kind = K_SLT;
            OP_ANDI: begin
               uop.kind = K_AND;
               uop.imm = {16'd0, instruction[15:0]};
            end
            OP_ORI: begin
               uop.kind = K_OR;
               uop.imm = {16'd0, instruction[15:0]};
            end
            OP_LUI: begin
               uop.kind = K_LUI;
               uop.imm = {instruction[15:0], 16'd0};
            end
            OP_LW:   uop.kind = K_LW;
            OP_SW:   uop.kind = K_SW;
            OP_BEQ:  uop.kind = K_BEQ;
            OP_BNE:  uop.kind = K_BNE;
            OP_J:    uop.kind = K_J;
            default: uop.unknown = 1'b1;
         endcase
      end
   end
endmodule

// ===== sv/mse_front.sv =====
module mse_front
   import mse_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   mse_req_if.sink req,
   output logic    q_valid,
   output uop_type q_uop,
   input  logic    q_pop
);
   // two-entry queue of decoded requests
   uop_type dec;
   uop_type slot_ff [2];
   logic    rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   mse_decode u_dec (.instruction(req.instruction), .uop(dec));

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_uop = slot_ff[rd_ff];

   always_comb begin
      rd_in = rd_ff ^ q_pop;
      wr_in = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= dec;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_pop: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> rd_ff == wr_ff)
      else $error("pointer mismatch");
endmodule

// ===== sv/mse_back.sv =====
module mse_back
   import mse_pkg::*;
#(
   parameter int DMEM_WORDS = 16384
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  uop_type q_uop,
   output logic    q_pop,
   mse_rsp_if.source rsp
);
   localparam int AW = $clog2(DMEM_WORDS);
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [31:0] rf_ff [32];
   logic [31:0] pc_ff, pc_in;
   logic [31:0] a_ff, b_ff;
   logic [31:0] addr_ff;
   logic        inr_ff;
   logic        rv_ff, rv_in;
   rsp_type     rp_ff, rp_in;
   logic [31:0] a_rd, b_rd, addr_c, off_c, opb, dval, pc4, npc;
   logic        inr_c, wr, st, fault, exec;
   logic        m_we;
   logic [AW-1:0] m_wa, m_ra;
   logic [31:0] m_wd, m_rd;

   mse_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));

   always_comb begin
      a_rd = rf_ff[q_uop.rs];
      b_rd = rf_ff[q_uop.rt];
      addr_c = a_rd + q_uop.imm;
      off_c = addr_c - DMEM_BASE;
      inr_c = ({1'b0, off_c} < (33'(DMEM_WORDS) << 2));
      m_ra = off_c[AW+1:2];
   end

   assign exec = (state_ff == S_EXEC) && (!rv_ff || rsp.ready);
   assign q_pop = exec;

   always_comb begin
      opb = q_uop.use_imm ? q_uop.imm : b_ff;
      pc4 = pc_ff + 32'd4;
      npc = pc4;
      wr = 1'b0; st = 1'b0; fault = 1'b0; dval = '0;
      unique case (q_uop.kind)
         K_ADD: begin dval = a_ff + opb; wr = 1'b1; end
         K_SUB: begin dval = a_ff - opb; wr = 1'b1; end
         K_AND: begin dval = a_ff & opb; wr = 1'b1; end
         K_OR:  begin dval = a_ff | opb; wr = 1'b1; end
         K_SLT: begin
            dval = {31'd0, $signed(a_ff) < $signed(opb)}; wr = 1'b1;
         end
         K_LUI: begin dval = q_uop.imm; wr = 1'b1; end
         K_LW: begin
            dval = m_rd; wr = inr_ff; fault = !inr_ff;
         end
         K_SW: begin st = inr_ff; fault = !inr_ff; end
         K_BEQ: if (a_ff == b_ff) npc = pc4 + {q_uop.imm[29:0], 2'b00};
         K_BNE: if (a_ff != b_ff) npc = pc4 + {q_uop.imm[29:0], 2'b00};
         K_J:   npc = {pc4[31:28], q_uop.target, 2'b00};
         default: ;
      endcase
      if (q_uop.dest == 5'd0) wr = 1'b0;
      rp_in = rp_ff;
      rv_in = rv_ff && !rsp.ready;
      pc_in = pc_ff;
      if (exec) begin
         rv_in = 1'b1;
         pc_in = npc;
         rp_in.next_pc = npc;
         rp_in.reg_written = wr;
         rp_in.dest_reg = wr ? q_uop.dest : 5'd0;
         rp_in.dest_value = wr ? dval : 32'd0;
         rp_in.mem_stored = st;
         rp_in.store_addr = st ? addr_ff : 32'd0;
         rp_in.store_value = st ? b_ff : 32'd0;
         rp_in.addr_fault = fault;
         rp_in.unknown_op = q_uop.unknown;
      end
      m_we = 1'b0;
      m_wa = addr_ff[AW+1:2] - DMEM_BASE[AW+1:2];
      m_wd = b_ff;
      if (state_ff == S_CLEAR) begin
         m_we = 1'b1;
         m_wa = clr_ff[AW-1:0];
         m_wd = '1;
      end else if (exec && q_uop.kind == K_SW && inr_ff) begin
         m_we = 1'b1;
      end
      state_in = state_ff;
      clr_in = clr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DMEM_WORDS - 1)) state_in = S_READ;
         end
         S_READ: if (q_valid) state_in = S_EXEC;
         S_EXEC: if (exec) state_in = S_READ;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pc_ff <= '0;
         rv_ff <= 1'b0;
         for (int i = 0; i < 32; i++) rf_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pc_ff <= pc_in;
         rv_ff <= rv_in;
         if (exec && wr) rf_ff[q_uop.dest] <= dval;
      end
      rp_ff <= rp_in;
      if (state_ff == S_READ) begin
         a_ff <= a_rd;
         b_ff <= b_rd;
         addr_ff <= addr_c;
         inr_ff <= inr_c;
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.payload = rp_ff;

   a_r0: assert property (@(posedge clock) disable iff (reset) rf_ff[0] == 32'd0)
      else $error("register zero written");
   a_once: assert property (@(posedge clock) disable iff (reset)
      exec |=> state_ff == S_READ)
      else $error("exec not followed by read");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rp_ff.reg_written |-> !rp_ff.mem_stored && !rp_ff.addr_fault)
      else $error("conflicting response flags");
endmodule

// ===== sv/mips_subset_execute.sv =====
// Executes one MIPS instruction word per request against a 32-entry register
// file, the program counter and a DMEM_WORDS-word data memory at 0x10000000,
// giving one response per request. The front decodes into a two-entry queue;
// the back reads registers and the data memory in its read state and retires in
// its execute state, which waits while the previous response is still held. The
// back takes a new request only after retiring the last; the data memory read is
// registered. After reset the back sweeps the data memory to all ones before
// the first retire; requests are still queued (up to two) meanwhile.
module mips_subset_execute
   import mse_pkg::*;
#(
   parameter int DMEM_WORDS = 16384
) (
   input  logic clock,
   input  logic reset,
   mse_req_if.sink   req,
   mse_rsp_if.source rsp
);
   logic    q_valid, q_pop;
   uop_type q_uop;

   // front: accept and classify
   mse_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_uop(q_uop), .q_pop(q_pop));

   // back: read operands, execute, hold the response
   mse_back #(.DMEM_WORDS(DMEM_WORDS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_uop(q_uop), .q_pop(q_pop), .rsp(rsp));
endmodule
